[rtl/take_back_half_velocity_controller_macros.svh]
// Assertion helpers used by the checker file.
`ifndef TAKE_BACK_HALF_VELOCITY_CONTROLLER_MACROS_SVH
`define TAKE_BACK_HALF_VELOCITY_CONTROLLER_MACROS_SVH

// Check a same-cycle implication, ignored while reset is asserted.
`define TBHVC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbhvc: same-cycle check failed");

// Check a next-cycle implication, ignored while reset is asserted.
`define TBHVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbhvc: next-cycle check failed");

`endif

[rtl/tbhvc_pkg.sv]
package tbhvc_pkg;

    // Drive fixed point format
    localparam int unsigned DRIVE_FRAC_BITS = 16;
    localparam int unsigned DRIVE_W = DRIVE_FRAC_BITS + 1;
    localparam logic [DRIVE_W-1:0] DRIVE_ONE = {1'b1, {DRIVE_FRAC_BITS{1'b0}}};
    localparam int unsigned GAIN_SHIFT = 28 - DRIVE_FRAC_BITS;
    localparam int unsigned DRV_UP = (DRIVE_FRAC_BITS >= 16) ? DRIVE_FRAC_BITS - 16 : 0;
    localparam int unsigned DRV_DN = (DRIVE_FRAC_BITS < 16) ? 16 - DRIVE_FRAC_BITS : 0;
    localparam logic [16:0] Q16_ONE = 17'd65536;

    // Velocity measurement widths
    localparam int unsigned VEL_W = 24;
    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam int unsigned SCALE_W = 20;
    localparam logic [SCALE_W-1:0] RPM_SCALE = 20'd960000;   // 60000 * 16
    localparam int unsigned NUM_W = 32 + SCALE_W;
    localparam int unsigned DEN_W = 32 + 16;
    localparam int unsigned QUO_W = VEL_W;
    localparam int unsigned DSH_W = DEN_W + QUO_W - 1;
    localparam int unsigned CNT_W = $clog2(QUO_W);

    // Control loop widths
    localparam int unsigned ERR_W = VEL_W + 1;
    localparam int unsigned PROD_W = 2 * ERR_W;
    localparam int unsigned SUM_W = PROD_W + 1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN = 1'b1;
    localparam int unsigned CFG_DATA_W = 24;

    // Item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] encoder_count;
        logic [31:0]        time_ms;
        logic signed [15:0] target_rpm;
        logic [16:0]        open_loop_drive;
    } t_in_item;

    typedef struct packed {
        logic [6:0]              motor_power;
        logic signed [VEL_W-1:0] velocity_rpm_x16;
        logic [16:0]             drive_fraction;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic meas;
        logic mul_num;
        logic mul_den;
        logic div_init;
        logic div_step;
        logic sat;
        logic err_mul;
        logic update;
        logic set_load;
        logic set_sign;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip;
        logic div_done;
    } t_dp_sts;

    // Q1.16 prediction (saturated to 1.0) into the drive format
    function automatic logic [DRIVE_W-1:0] to_drive(input logic [16:0] p);
        logic [16:0]         ps;
        logic [DRIVE_W+16:0] w;
        ps = (p > Q16_ONE) ? Q16_ONE : p;
        w = {{DRIVE_W{1'b0}}, ps};
        w = w << DRV_UP;
        w = w >> DRV_DN;
        return w[DRIVE_W-1:0];
    endfunction

    // Drive format into Q1.16
    function automatic logic [16:0] from_drive(input logic [DRIVE_W-1:0] d);
        logic [DRIVE_W+16:0] w;
        w = {17'd0, d};
        w = w << DRV_DN;
        w = w >> DRV_UP;
        return w[16:0];
    endfunction

endpackage

[rtl/tbhvc_ctrl.sv]
module tbhvc_ctrl
    import tbhvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_cmd,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_dp_cmd,
    input  t_dp_sts i_dp_sts
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MEAS = 12'b0000_0000_0010,
        S_MULN = 12'b0000_0000_0100,
        S_MULD = 12'b0000_0000_1000,
        S_OVF  = 12'b0000_0001_0000,
        S_DIV  = 12'b0000_0010_0000,
        S_SAT  = 12'b0000_0100_0000,
        S_ERRM = 12'b0000_1000_0000,
        S_UPD  = 12'b0001_0000_0000,
        S_SETL = 12'b0010_0000_0000,
        S_SETS = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Sequence one item through the datapath
    always_comb begin
        n_state = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state = (i_cmd == CMD_SET) ? S_SETL : S_MEAS;
                end
            end
            S_MEAS: begin
                o_dp_cmd.meas = 1'b1;
                n_state = S_MULN;
            end
            S_MULN: begin
                o_dp_cmd.mul_num = 1'b1;
                n_state = S_MULD;
            end
            S_MULD: begin
                o_dp_cmd.mul_den = 1'b1;
                n_state = i_dp_sts.skip ? S_ERRM : S_OVF;
            end
            S_OVF: begin
                o_dp_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                if (i_dp_sts.div_done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_dp_cmd.sat = 1'b1;
                n_state = S_ERRM;
            end
            S_ERRM: begin
                o_dp_cmd.err_mul = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_dp_cmd.update = 1'b1;
                n_state = S_DONE;
            end
            S_SETL: begin
                o_dp_cmd.set_load = 1'b1;
                n_state = S_SETS;
            end
            S_SETS: begin
                o_dp_cmd.set_sign = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait for the output register to free up
                if (!r_out_valid || i_ready) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        n_out_valid = o_dp_cmd.load_out | (r_out_valid & ~i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/tbhvc_dp.sv]
module tbhvc_dp
    import tbhvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_item,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_cmd               i_dp_cmd,
    output t_dp_sts               o_dp_sts
);

    // Configuration
    logic [15:0] r_tpr;
    logic [23:0] r_gain;

    // Architectural state
    logic [31:0]             r_last_count;
    logic [31:0]             r_last_time;
    logic signed [VEL_W-1:0] r_velocity;
    logic [DRIVE_W-1:0]      r_drive;
    logic [DRIVE_W-1:0]      r_crossing;
    logic                    r_pending;
    t_sign                   r_last_sign;
    logic signed [15:0]      r_target;
    logic [DRIVE_W-1:0]      r_estimate;

    // Working registers
    t_in_item                r_item;
    logic [31:0]             r_mag;
    logic                    r_neg;
    logic [31:0]             r_dt;
    logic                    r_skip;
    logic [NUM_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_den;
    logic                    r_ovf;
    logic [NUM_W-1:0]        r_rem;
    logic [DSH_W-1:0]        r_dsh;
    logic [QUO_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    t_sign                   r_err_sign;
    t_out_item               r_out;

    // Combinational helpers
    logic [31:0]             dc, dt;
    logic [15:0]             tpr_eff;
    logic                    ge;
    logic signed [ERR_W-1:0] err;
    t_sign                   err_sign;
    logic [VEL_W-1:0]        n_velocity;
    logic signed [SUM_W-1:0] sum;
    logic [DRIVE_W-1:0]      clipped;
    logic [DRIVE_W:0]        mean;
    logic [DRIVE_W-1:0]      n_drive;
    logic [DRIVE_W+6:0]      motor;

    // Deltas since the last tick, and zero ticks per rev read as one
    always_comb begin
        dc = r_item.encoder_count - r_last_count;
        dt = r_item.time_ms - r_last_time;
        tpr_eff = (r_tpr == 16'd0) ? 16'd1 : r_tpr;
        ge = ({{(DSH_W-NUM_W){1'b0}}, r_rem} >= r_dsh);
    end

    // Saturate the quotient into the velocity range
    always_comb begin
        if (r_neg) begin
            n_velocity = (r_ovf || r_quo > VEL_MIN) ? VEL_MIN : (~r_quo + 1'b1);
        end else begin
            n_velocity = (r_ovf || r_quo[QUO_W-1]) ? VEL_MAX : r_quo;
        end
    end

    // Velocity error in rpm*16 and its sign
    always_comb begin
        err = $signed({{5{r_target[15]}}, r_target, 4'b0000})
            - $signed({r_velocity[VEL_W-1], r_velocity});
        if (err[ERR_W-1]) begin
            err_sign = SIGN_NEG;
        end else if (err != '0) begin
            err_sign = SIGN_POS;
        end else begin
            err_sign = SIGN_ZERO;
        end
    end

    // Integrate, clip to 0..1, take back half on a sign change (open-loop estimate at the first change after a set)
    always_comb begin
        sum = $signed({{(SUM_W-DRIVE_W){1'b0}}, r_drive})
            + $signed({r_prod[PROD_W-1], (r_prod >>> GAIN_SHIFT)});
        if (sum[SUM_W-1]) begin
            clipped = '0;
        end else if (sum[SUM_W-2:0] > {{(SUM_W-1-DRIVE_W){1'b0}}, DRIVE_ONE}) begin
            clipped = DRIVE_ONE;
        end else begin
            clipped = sum[DRIVE_W-1:0];
        end
        mean = {1'b0, clipped} + {1'b0, r_crossing};
        if (r_err_sign == r_last_sign) begin
            n_drive = clipped;
        end else if (r_pending) begin
            n_drive = r_estimate;
        end else begin
            n_drive = mean[DRIVE_W:1];
        end
    end

    // Motor command: drive*127 rounded
    always_comb begin
        motor = ({7'd0, r_drive} << 7) - {7'd0, r_drive}
              + ({{(DRIVE_W+6){1'b0}}, 1'b1} << (DRIVE_FRAC_BITS - 1));
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr <= 16'd360;
            r_gain <= 24'd67109;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TICKS_PER_REV: r_tpr <= i_cfg_wdata[15:0];
                CFG_LOOP_GAIN:     r_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Controller state of the regulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_last_time <= '0;
            r_velocity <= '0;
            r_drive <= '0;
            r_crossing <= '0;
            r_pending <= 1'b0;
            r_last_sign <= SIGN_ZERO;
            r_target <= '0;
            r_estimate <= '0;
        end else begin
            if (i_dp_cmd.meas) begin
                r_last_count <= r_item.encoder_count;
                r_last_time <= r_item.time_ms;
            end
            if (i_dp_cmd.sat) begin
                r_velocity <= n_velocity;
            end
            if (i_dp_cmd.update) begin
                r_drive <= n_drive;
                r_last_sign <= r_err_sign;
                if (r_err_sign != r_last_sign) begin
                    r_crossing <= n_drive;
                    r_pending <= 1'b0;
                end
            end
            if (i_dp_cmd.set_load) begin
                r_target <= r_item.target_rpm;
                r_estimate <= to_drive(r_item.open_loop_drive);
                r_pending <= 1'b1;
                r_crossing <= '0;
            end
            if (i_dp_cmd.set_sign) begin
                r_last_sign <= err_sign;
            end
        end
    end

    // Item capture, measurement, restoring divider, error multiply and output register
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_dp_cmd.meas) begin
            r_neg <= dc[31];
            r_mag <= dc[31] ? (~dc + 1'b1) : dc;
            r_dt <= dt;
            r_skip <= (dc == '0) || (dt == '0);
        end
        if (i_dp_cmd.mul_num) begin
            r_num <= r_mag * RPM_SCALE;
        end
        if (i_dp_cmd.mul_den) begin
            r_den <= r_dt * tpr_eff;
        end
        if (i_dp_cmd.div_init) begin
            r_ovf <= ({{(DEN_W+QUO_W-NUM_W){1'b0}}, r_num} >= {r_den, {QUO_W{1'b0}}});
            r_rem <= r_num;
            r_dsh <= {r_den, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
            r_cnt <= CNT_W'(QUO_W - 1);
        end
        if (i_dp_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh[NUM_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_dp_cmd.err_mul) begin
            r_prod <= err * $signed({1'b0, r_gain});
            r_err_sign <= err_sign;
        end
        if (i_dp_cmd.load_out) begin
            r_out.motor_power <= motor[DRIVE_FRAC_BITS+6:DRIVE_FRAC_BITS];
            r_out.velocity_rpm_x16 <= r_velocity;
            r_out.drive_fraction <= from_drive(r_drive);
        end
    end

    assign o_dp_sts.skip = r_skip;
    assign o_dp_sts.div_done = (r_cnt == '0);
    assign o_result = r_out;

endmodule

[rtl/take_back_half_velocity_controller.sv]
// A control tick runs the measurement, the 24-step restoring divider for the
// velocity quotient, the error multiply and the update; the divider is skipped
// when the count or time is unchanged. A set item loads the target and estimate,
// then the error sign. A new item is taken only once the last result is registered.
// Reset (synchronous, active low) clears all regulator state and loads
// ticks_per_revolution 360 and loop_gain 67109.
module take_back_half_velocity_controller
    import tbhvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    tbhvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_item.cmd),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_dp_cmd (dp_cmd),
        .i_dp_sts (dp_sts)
    );

    // Measurement and control arithmetic
    tbhvc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dp_cmd    (dp_cmd),
        .o_dp_sts    (dp_sts)
    );

endmodule

[rtl/tbhvc_checker.sv]
`include "take_back_half_velocity_controller_macros.svh"

module tbhvc_checker
    import tbhvc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_result
);

    // A stalled result word holds
    `TBHVC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_result))

    // An accepted word keeps the block busy in the next cycle
    `TBHVC_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

    // A new result appears only as the block goes back to waiting for input
    `TBHVC_ASSERT_NOW(a_rise_then_ready, $rose(o_valid), o_ready)

    // The reported drive never exceeds full scale
    `TBHVC_ASSERT_NOW(a_drive_bound, o_valid, o_result.drive_fraction <= Q16_ONE)

endmodule

bind take_back_half_velocity_controller tbhvc_checker u_checker (.*);
